// ----- rtl/slx_pkg.sv -----
// Shared types, character codes, token codes and character classification for the lexer.
`default_nettype none

package slx_pkg;

    localparam int COLUMN_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int CFG_IDX_BITS    = 1;
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS      = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_LINE   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_COLUMN = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [2:0] KIND_SYM   = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_FLOAT = 3'd2;
    localparam logic [2:0] KIND_OP    = 3'd3;
    localparam logic [2:0] KIND_DELIM = 3'd4;
    localparam logic [2:0] KIND_EOF   = 3'd5;
    localparam logic [2:0] KIND_ERR   = 3'd6;

    localparam logic [3:0] SUB_NONE = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_MOD   = 4'd4;
    localparam logic [3:0] OP_EQ    = 4'd5;
    localparam logic [3:0] OP_DEF   = 4'd6;
    localparam logic [3:0] OP_NE    = 4'd7;
    localparam logic [3:0] OP_NOT   = 4'd8;
    localparam logic [3:0] OP_LE    = 4'd9;
    localparam logic [3:0] OP_LT    = 4'd10;
    localparam logic [3:0] OP_GE    = 4'd11;
    localparam logic [3:0] OP_GT    = 4'd12;
    localparam logic [3:0] DL_LBRK  = 4'd0;
    localparam logic [3:0] DL_LBRC  = 4'd1;
    localparam logic [3:0] DL_LPAR  = 4'd2;
    localparam logic [3:0] DL_RPAR  = 4'd3;
    localparam logic [3:0] DL_RBRC  = 4'd4;
    localparam logic [3:0] DL_RBRK  = 4'd5;
    localparam logic [3:0] DL_COMMA = 4'd6;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SYM  = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_OP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [2:0]            kind;
        logic [3:0]            sub;
        logic [FIELD_BITS-1:0] line;
        logic [FIELD_BITS-1:0] bcol;
        logic [FIELD_BITS-1:0] ecol;
        logic                  last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    typedef struct packed {
        logic [Q_CNT_BITS-1:0] count;
        logic                  room;
    } t_qstat;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] sub;
    } t_class;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
    endfunction

    function automatic logic [3:0] op_single(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            CH_EQ:   s = OP_DEF;
            CH_BANG: s = OP_NOT;
            CH_LT:   s = OP_LT;
            default: s = OP_GT;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] op_double(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            CH_EQ:   s = OP_EQ;
            CH_BANG: s = OP_NE;
            CH_LT:   s = OP_LE;
            default: s = OP_GE;
        endcase
        return s;
    endfunction

    // Kind and subkind of a byte that forms a whole token on its own.
    function automatic t_class single_class(input logic [7:0] c);
        t_class r;
        case (c)
            CH_MINUS: r = '{KIND_OP, OP_SUB};
            CH_PLUS:  r = '{KIND_OP, OP_ADD};
            CH_STAR:  r = '{KIND_OP, OP_MUL};
            CH_SLASH: r = '{KIND_OP, OP_DIV};
            CH_PCT:   r = '{KIND_OP, OP_MOD};
            CH_LBRK:  r = '{KIND_DELIM, DL_LBRK};
            CH_LBRC:  r = '{KIND_DELIM, DL_LBRC};
            CH_LPAR:  r = '{KIND_DELIM, DL_LPAR};
            CH_RPAR:  r = '{KIND_DELIM, DL_RPAR};
            CH_RBRC:  r = '{KIND_DELIM, DL_RBRC};
            CH_RBRK:  r = '{KIND_DELIM, DL_RBRK};
            CH_COMMA: r = '{KIND_DELIM, DL_COMMA};
            default:  r = '{KIND_ERR, SUB_NONE};
        endcase
        return r;
    endfunction

    function automatic t_mode mode_after_idle(input logic [7:0] c);
        t_mode m;
        if (c == CH_NUL) begin
            m = MODE_IDLE;
        end else if (is_letter(c)) begin
            m = MODE_SYM;
        end else if (is_digit(c) || c == CH_DOT) begin
            m = MODE_NUM;
        end else if (is_opchar(c)) begin
            m = MODE_OP;
        end else begin
            m = MODE_IDLE;
        end
        return m;
    endfunction

    function automatic logic [2:0] num_kind(input logic [1:0] dots);
        logic [2:0] k;
        case (dots)
            2'd0:    k = KIND_INT;
            2'd1:    k = KIND_FLOAT;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/source_lexer_unit.sv -----
// A token enters the token queue when the byte that ends it is accepted, and leaves in order.
// Throughput: one byte per cycle while the queue has room; a byte may end two tokens.
// The four-entry token queue takes a byte whenever it has room for two tokens.
// Reset is synchronous and active low: lexer idle, start line and start column zero.
// Queue contents are not cleared by reset; only its pointers and count are.
`default_nettype none

module source_lexer_unit #(
    parameter int COLUMN_BITS = slx_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [slx_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [slx_pkg::FIELD_BITS-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [7:0]                       i_char_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [2:0]                            o_token_kind,
    output logic [3:0]                            o_sub_kind,
    output logic [slx_pkg::FIELD_BITS-1:0]        o_line_no,
    output logic [slx_pkg::FIELD_BITS-1:0]        o_begin_column,
    output logic [slx_pkg::FIELD_BITS-1:0]        o_end_column,
    output logic                                  o_last
);
    import slx_pkg::*;

    t_push  push;
    t_qstat qstat;
    t_token tok;

    slx_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_char_in   (i_char_in),
        .i_qstat     (qstat),
        .o_in_ready  (o_in_ready),
        .o_push      (push)
    );

    slx_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_token     (tok),
        .o_qstat     (qstat)
    );

    assign o_token_kind   = tok.kind;
    assign o_sub_kind     = tok.sub;
    assign o_line_no      = tok.line;
    assign o_begin_column = tok.bcol;
    assign o_end_column   = tok.ecol;
    assign o_last         = tok.last;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= Q_CNT_BITS'(Q_DEPTH))
        else $error("token queue count exceeds its depth");

    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && i_out_ready |=> o_out_valid)
        else $error("second token of a byte is missing");

    a_eof_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == KIND_EOF |-> o_begin_column == o_end_column && o_last)
        else $error("end-of-file token has a nonempty span or is not last");

    a_sub_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != KIND_OP && o_token_kind != KIND_DELIM
        |-> o_sub_kind == SUB_NONE)
        else $error("subkind set on a token that has none");
`endif

endmodule

`default_nettype wire

// ----- rtl/slx_front.sv -----
// Lexer front end: configuration registers, lexer state and per-byte token generation.
`default_nettype none

module slx_front #(
    parameter int COLUMN_BITS = slx_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [slx_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [slx_pkg::FIELD_BITS-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic [7:0]                         i_char_in,
    input  wire slx_pkg::t_qstat                    i_qstat,
    output logic                                    o_in_ready,
    output slx_pkg::t_push                          o_push
);
    import slx_pkg::*;

    logic [FIELD_BITS-1:0]  r_start_line;
    logic [COLUMN_BITS-1:0] r_start_col;
    t_mode                  r_mode,      n_mode;
    logic [COLUMN_BITS-1:0] r_tok_start, n_tok_start;
    logic [COLUMN_BITS-1:0] r_col,       n_col;
    logic [1:0]             r_dots,      n_dots;
    logic [7:0]             r_pending,   n_pending;

    logic                   accept;
    logic [COLUMN_BITS-1:0] col_ones;
    logic [COLUMN_BITS-1:0] nxt;
    logic [31:0]            w_col, w_nxt, w_start, w_cfg;
    logic [FIELD_BITS-1:0]  col16, nxt16, start16;
    logic [COLUMN_BITS-1:0] cfg_col;
    logic                   pre_v, idl_v, fall;
    t_token                 pre_t, idl_t;
    t_class                 cls;
    logic [7:0]             c;

    assign c          = i_char_in;
    assign o_in_ready = i_qstat.room;
    assign accept     = i_in_valid && o_in_ready;
    assign col_ones   = '1;
    assign nxt        = (r_col == col_ones) ? r_col : r_col + 1'b1;

    assign w_col   = 32'(r_col);
    assign w_nxt   = 32'(nxt);
    assign w_start = 32'(r_tok_start);
    assign col16   = w_col[FIELD_BITS-1:0];
    assign nxt16   = w_nxt[FIELD_BITS-1:0];
    assign start16 = w_start[FIELD_BITS-1:0];

    assign w_cfg   = 32'(i_cfg_data);
    assign cfg_col = (w_cfg > 32'(col_ones)) ? col_ones : w_cfg[COLUMN_BITS-1:0];
    assign cls     = single_class(c);

    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_SYM: begin
                n_mode = (is_letter(c) || is_digit(c)) ? MODE_SYM : mode_after_idle(c);
            end
            MODE_NUM: begin
                n_mode = (is_digit(c) || c == CH_DOT) ? MODE_NUM : mode_after_idle(c);
            end
            MODE_OP: begin
                n_mode = (c == CH_EQ) ? MODE_IDLE : mode_after_idle(c);
            end
            default: begin
                n_mode = mode_after_idle(c);
            end
        endcase
    end

    always_comb begin
        pre_v       = 1'b0;
        idl_v       = 1'b0;
        pre_t       = '0;
        idl_t       = '0;
        fall        = 1'b1;
        n_tok_start = r_tok_start;
        n_col       = r_col;
        n_dots      = r_dots;
        n_pending   = r_pending;
        pre_t.line  = r_start_line;
        idl_t.line  = r_start_line;

        case (r_mode)
            MODE_SYM: begin
                if (is_letter(c) || is_digit(c)) begin
                    n_col = nxt;
                    fall  = 1'b0;
                end else begin
                    pre_v      = 1'b1;
                    pre_t.kind = KIND_SYM;
                    pre_t.bcol = start16;
                    pre_t.ecol = col16;
                end
            end
            MODE_NUM: begin
                if (is_digit(c) || c == CH_DOT) begin
                    if (c == CH_DOT && r_dots != 2'd2) begin
                        n_dots = r_dots + 2'd1;
                    end
                    n_col = nxt;
                    fall  = 1'b0;
                end else begin
                    pre_v      = 1'b1;
                    pre_t.kind = num_kind(r_dots);
                    pre_t.bcol = start16;
                    pre_t.ecol = col16;
                    n_dots     = 2'd0;
                end
            end
            MODE_OP: begin
                pre_v      = 1'b1;
                pre_t.kind = KIND_OP;
                pre_t.bcol = start16;
                if (c == CH_EQ) begin
                    pre_t.sub  = op_double(r_pending);
                    pre_t.ecol = nxt16;
                    n_col      = nxt;
                    fall       = 1'b0;
                end else begin
                    pre_t.sub  = op_single(r_pending);
                    pre_t.ecol = col16;
                end
            end
            default: begin
            end
        endcase

        if (fall) begin
            if (c == CH_NUL) begin
                idl_v      = 1'b1;
                idl_t.kind = KIND_EOF;
                idl_t.bcol = col16;
                idl_t.ecol = col16;
                n_dots     = 2'd0;
                n_col      = r_start_col;
            end else if (c == CH_SPACE) begin
                n_col = nxt;
            end else if (is_letter(c)) begin
                n_tok_start = r_col;
                n_col       = nxt;
            end else if (is_digit(c) || c == CH_DOT) begin
                n_tok_start = r_col;
                n_dots      = (c == CH_DOT) ? 2'd1 : 2'd0;
                n_col       = nxt;
            end else if (is_opchar(c)) begin
                n_tok_start = r_col;
                n_pending   = c;
                n_col       = nxt;
            end else begin
                idl_v      = 1'b1;
                idl_t.kind = cls.kind;
                idl_t.sub  = cls.sub;
                idl_t.bcol = col16;
                idl_t.ecol = nxt16;
                n_col      = nxt;
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (pre_v && idl_v) begin
            o_push.count     = 2'd2;
            o_push.tok0      = pre_t;
            o_push.tok1      = idl_t;
            o_push.tok1.last = 1'b1;
        end else if (pre_v) begin
            o_push.count     = 2'd1;
            o_push.tok0      = pre_t;
            o_push.tok0.last = 1'b1;
        end else if (idl_v) begin
            o_push.count     = 2'd1;
            o_push.tok0      = idl_t;
            o_push.tok0.last = 1'b1;
        end
        if (!accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_line <= '0;
            r_start_col  <= '0;
            r_mode       <= MODE_IDLE;
            r_tok_start  <= '0;
            r_col        <= '0;
            r_dots       <= '0;
            r_pending    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_START_LINE) begin
                r_start_line <= i_cfg_data;
            end else if (i_cfg_index == CFG_START_COLUMN) begin
                r_start_col <= cfg_col;
                r_col       <= cfg_col;
            end
        end else if (accept) begin
            r_mode      <= n_mode;
            r_tok_start <= n_tok_start;
            r_col       <= n_col;
            r_dots      <= n_dots;
            r_pending   <= n_pending;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/slx_queue.sv -----
// Token queue between the lexer front end and the output port, up to two writes and one read a cycle.
`default_nettype none

module slx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire slx_pkg::t_push i_push,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output slx_pkg::t_token     o_token,
    output slx_pkg::t_qstat     o_qstat
);
    import slx_pkg::*;

    t_token                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count,  n_count;
    logic                  pop;
    logic [Q_PTR_BITS-1:0] wr_ptr1;

    assign o_out_valid   = (r_count != '0);
    assign o_token       = r_mem[r_rd_ptr];
    assign pop           = o_out_valid && i_out_ready;
    assign wr_ptr1       = r_wr_ptr + 1'b1;
    assign o_qstat.count = r_count;
    assign o_qstat.room  = (r_count <= Q_CNT_BITS'(Q_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_BITS'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CNT_BITS'(i_push.count) - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire
